// File: rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int PAGE_W  = 10;
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 5;
  localparam int FRAME_W = 4;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [STAMP_W-1:0] SAT_MAX   = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_RESULT
  } st_t;

  // token handed down the cell row during the oldest-stamp search
  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  pos;
    logic [SLOT_W-1:0]  idx;
    logic [STAMP_W-1:0] stamp;
    logic [PAGE_W-1:0]  page;
  } tok_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [PAGE_W-1:0]  key;
    logic [STAMP_W-1:0] stamp;
  } cell_ctl_t;

  function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + STAMP_W'(1);
  endfunction

endpackage

// File: rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// True LRU page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// One word in, one word out. A reference that hits, or that misses while a
// frame is still free, goes through the lookup, decide and result states to
// the output register, and the next word is taken back in idle. A miss that
// must evict adds a scan state, in which the oldest stamp is found by a token
// that walks the row of FRAMES cells, one cell per cycle.
// The next word is accepted once
// the current result sits in the output register; a stalled output holds the
// block until its word is taken. Residency is found by matching the page
// against all filled cells at once, so no per-page table exists and no
// clearing pass follows reset.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PAGE_W-1:0]   in_page,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_fault,
  output logic                out_evicted,
  output logic [PAGE_W-1:0]   out_evict_page,
  output logic [FRAME_W-1:0]  out_frame,
  output logic [STAMP_W-1:0]  out_fault_count,
  output logic [STAMP_W-1:0]  out_replacement_count
);

  localparam int FC_W = $clog2(FRAMES + 1);

  st_t                state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [PAGE_W-1:0]  key_r;
  logic [STAMP_W-1:0] cnt_r;
  logic [FC_W-1:0]    filled_r;
  logic [FC_W-1:0]    scan_r;
  logic [FRAMES-1:0]  hit_r;
  logic [FRAMES-1:0]  hit_w;
  logic [FRAMES-1:0]  wr_en;
  logic [FC_W-1:0]    eff_w;

  logic               res_fault_r, res_evict_r;
  logic [PAGE_W-1:0]  res_victim_r;
  logic [SLOT_W-1:0]  res_slot_r;
  logic [STAMP_W-1:0] ftot_r, rtot_r;
  logic [STAMP_W-1:0] ftot_nxt, rtot_nxt;

  logic               out_valid_r;
  logic               out_fault_r, out_evicted_r;
  logic [PAGE_W-1:0]  out_victim_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [STAMP_W-1:0] out_fcnt_r, out_rcnt_r;

  logic               wr_go, fill_inc, out_load, scan_last, free_slot;
  logic [SLOT_W-1:0]  wr_slot, hit_idx;
  logic               res_fault, res_evict;
  logic [PAGE_W-1:0]  res_victim;
  cell_ctl_t          ctl;
  tok_t               chain [FRAMES+1];

  // frame count clamped to 1..FRAMES
  always_comb begin
    if (32'(cfg_r) > FRAMES) begin
      eff_w = FC_W'(FRAMES);
    end else if (cfg_r == '0) begin
      eff_w = FC_W'(1);
    end else begin
      eff_w = FC_W'(cfg_r);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_r[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign free_slot = filled_r < eff_w;
  assign scan_last = scan_r == FC_W'(FRAMES - 1);

  assign ctl.key   = key_r;
  assign ctl.stamp = cnt_r;

  assign chain[0] = '0;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      assign wr_en[g] = wr_go && (wr_slot == SLOT_W'(g));
      lrupr_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .wr_en (wr_en[g]),
        .tok_i (chain[g]),
        .tok_o (chain[g+1]),
        .hit   (hit_w[g])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if ((|hit_r) || free_slot) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    wr_go      = 1'b0;
    wr_slot    = '0;
    fill_inc   = 1'b0;
    out_load   = 1'b0;
    res_fault  = 1'b0;
    res_evict  = 1'b0;
    res_victim = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LOOKUP: ;
      ST_DECIDE: begin
        if (|hit_r) begin
          wr_go   = 1'b1;
          wr_slot = hit_idx;
        end else if (free_slot) begin
          wr_go     = 1'b1;
          wr_slot   = SLOT_W'(filled_r);
          fill_inc  = 1'b1;
          res_fault = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          wr_go      = 1'b1;
          wr_slot    = chain[FRAMES].idx;
          res_fault  = 1'b1;
          res_evict  = 1'b1;
          res_victim = chain[FRAMES].page;
        end
      end
      ST_RESULT: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  assign ftot_nxt = res_fault_r ? sat_inc(ftot_r) : ftot_r;
  assign rtot_nxt = res_evict_r ? sat_inc(rtot_r) : rtot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r       <= CFG_RESET;
      cnt_r       <= '0;
      filled_r    <= '0;
      scan_r      <= '0;
      ftot_r      <= '0;
      rtot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      if (in_valid && in_ready) begin
        cnt_r <= sat_inc(cnt_r);
      end
      if (fill_inc) begin
        filled_r <= filled_r + FC_W'(1);
      end
      if (state_r == ST_SCAN) begin
        scan_r <= scan_r + FC_W'(1);
      end else begin
        scan_r <= '0;
      end
      if (out_load) begin
        ftot_r      <= ftot_nxt;
        rtot_r      <= rtot_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= in_page;
    end
    if (state_r == ST_LOOKUP) begin
      hit_r <= hit_w;
    end
    if (wr_go) begin
      res_fault_r  <= res_fault;
      res_evict_r  <= res_evict;
      res_victim_r <= res_victim;
      res_slot_r   <= wr_slot;
    end
    if (out_load) begin
      out_fault_r   <= res_fault_r;
      out_evicted_r <= res_evict_r;
      out_victim_r  <= res_victim_r;
      out_frame_r   <= res_slot_r[FRAME_W-1:0];
      out_fcnt_r    <= ftot_nxt;
      out_rcnt_r    <= rtot_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_fault             = out_fault_r;
  assign out_evicted           = out_evicted_r;
  assign out_evict_page        = out_victim_r;
  assign out_frame             = out_frame_r;
  assign out_fault_count       = out_fcnt_r;
  assign out_replacement_count = out_rcnt_r;

endmodule

// File: rtl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// lrupr_cell
// One frame slot: holds page and last-use stamp, matches the looked-up page
// and passes the oldest-so-far token on to its neighbor every cycle.
// ----------------------------------------------------------------------------
module lrupr_cell
  import lrupr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      wr_en,
  input  tok_t      tok_i,
  output tok_t      tok_o,
  output logic      hit
);

  logic               filled_r;
  logic [PAGE_W-1:0]  page_r;
  logic [STAMP_W-1:0] stamp_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic               take_own;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
    end else if (wr_en) begin
      filled_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_r  <= ctl.key;
      stamp_r <= ctl.stamp;
    end
  end

  assign hit = filled_r && (page_r == ctl.key);

  // strict compare keeps the lower slot on equal stamps
  assign take_own = filled_r && (!tok_i.found || (stamp_r < tok_i.stamp));

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.pos = tok_i.pos + SLOT_W'(1);
    if (take_own) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = tok_i.pos;
      tok_nxt.stamp = stamp_r;
      tok_nxt.page  = page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
